// File: sv/fswp_pkg.sv
// Shared types, constants and the arctangent table of the wrapped-phase pipeline.
`default_nettype none

package fswp_pkg;

  // Number of CORDIC iterations, one pipeline stage each.
  localparam int CORDIC_STEPS = 30;

  // Register stages ahead of the CORDIC: differences, shift search, normalising shift.
  localparam int FRONT_STAGES = 3;

  // Total register stages from input to the output register.
  localparam int STAGES = FRONT_STAGES + CORDIC_STEPS + 1;

  // The larger magnitude is normalised into [2^NORM_TOP, 2^(NORM_TOP+1)).
  localparam int NORM_TOP = 40;

  // Width of the CORDIC vector datapath; covers the gain and the sign.
  localparam int WORK_BITS = 45;

  // Width of the normalising shift amount.
  localparam int SHIFT_BITS = 6;

  // Angle accumulator width, in units of 2pi / 2^32, signed.
  localparam int ANGLE_BITS = 33;

  // Placed angles on the 2^32 turn.
  localparam logic [ANGLE_BITS-1:0] ANGLE_FULL = 33'h1_0000_0000;
  localparam logic [ANGLE_BITS-1:0] ANGLE_HALF = 33'h0_8000_0000;

  // Upper clamp of the first-quadrant angle (a quarter turn).
  localparam int QUAD_BITS = 31;
  localparam logic [QUAD_BITS-1:0] QUAD_MAX = 31'h4000_0000;

  typedef logic signed [WORK_BITS-1:0]  work_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic [SHIFT_BITS-1:0]        shift_t;

  // Quadrant and special-case flags that travel with each beat.
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
  } ctrl_t;

  // atan(2^-idx) in units of 2pi / 2^32.
  function automatic logic [31:0] arc_angle(input int idx);
    logic [31:0] value;
    unique case (idx)
      0:       value = 32'd536870912;
      1:       value = 32'd316933406;
      2:       value = 32'd167458907;
      3:       value = 32'd85004756;
      4:       value = 32'd42667331;
      5:       value = 32'd21354465;
      6:       value = 32'd10679838;
      7:       value = 32'd5340245;
      8:       value = 32'd2670163;
      9:       value = 32'd1335087;
      10:      value = 32'd667544;
      11:      value = 32'd333772;
      12:      value = 32'd166886;
      13:      value = 32'd83443;
      14:      value = 32'd41722;
      15:      value = 32'd20861;
      16:      value = 32'd10430;
      17:      value = 32'd5215;
      18:      value = 32'd2608;
      19:      value = 32'd1304;
      20:      value = 32'd652;
      21:      value = 32'd326;
      22:      value = 32'd163;
      23:      value = 32'd81;
      24:      value = 32'd41;
      25:      value = 32'd20;
      26:      value = 32'd10;
      27:      value = 32'd5;
      28:      value = 32'd3;
      29:      value = 32'd1;
      default: value = 32'd0;
    endcase
    return value;
  endfunction

endpackage

`default_nettype wire

// File: sv/fswp_in_if.sv
// Input channel carrying the four phase-shifted samples of one pixel.
`default_nettype none

interface fswp_in_if #(
  parameter int SAMPLE_BITS = 16
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_a;
  logic signed [SAMPLE_BITS-1:0] sample_b;
  logic signed [SAMPLE_BITS-1:0] sample_c;
  logic signed [SAMPLE_BITS-1:0] sample_d;

  modport source (
    output valid, sample_a, sample_b, sample_c, sample_d,
    input  ready
  );

  modport sink (
    input  valid, sample_a, sample_b, sample_c, sample_d,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/fswp_out_if.sv
// Output channel carrying the wrapped phase of one pixel.
`default_nettype none

interface fswp_out_if #(
  parameter int PHASE_BITS = 16
) ();

  logic                valid;
  logic                ready;
  logic [PHASE_BITS:0] wrapped_phase;

  modport source (
    output valid, wrapped_phase,
    input  ready
  );

  modport sink (
    input  valid, wrapped_phase,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/fswp_front.sv
// Front stages: differences and magnitudes, shift search, and normalisation.
`default_nettype none

module fswp_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [fswp_pkg::FRONT_STAGES-1:0]      en,
  input  wire logic                                   valid_in,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_a,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_b,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_c,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_d,
  output logic [fswp_pkg::FRONT_STAGES-1:0]           valid,
  output fswp_pkg::work_t                             x0,
  output fswp_pkg::work_t                             y0,
  output fswp_pkg::ctrl_t                             ctrl
);

  localparam int DIFF_BITS = SAMPLE_BITS + 1;

  logic signed [DIFF_BITS-1:0] diff_x;
  logic signed [DIFF_BITS-1:0] diff_y;
  logic [DIFF_BITS-1:0]        mag_x;
  logic [DIFF_BITS-1:0]        mag_y;
  fswp_pkg::ctrl_t             ctrl_a;

  logic [DIFF_BITS-1:0]        a_mag_x;
  logic [DIFF_BITS-1:0]        a_mag_y;
  fswp_pkg::ctrl_t             a_ctrl;

  logic [DIFF_BITS-1:0]        big;
  fswp_pkg::shift_t            msb;
  fswp_pkg::shift_t            shift_next;

  logic [DIFF_BITS-1:0]        b_mag_x;
  logic [DIFF_BITS-1:0]        b_mag_y;
  fswp_pkg::shift_t            b_shift;
  fswp_pkg::ctrl_t             b_ctrl;

  logic [fswp_pkg::WORK_BITS-1:0] ext_x;
  logic [fswp_pkg::WORK_BITS-1:0] ext_y;

  // Exact differences, their magnitudes and the quadrant flags.
  always_comb begin
    diff_x        = DIFF_BITS'(sample_a) - DIFF_BITS'(sample_c);
    diff_y        = DIFF_BITS'(sample_d) - DIFF_BITS'(sample_b);
    mag_x         = diff_x[DIFF_BITS-1] ? DIFF_BITS'(-diff_x) : DIFF_BITS'(diff_x);
    mag_y         = diff_y[DIFF_BITS-1] ? DIFF_BITS'(-diff_y) : DIFF_BITS'(diff_y);
    ctrl_a.x_zero = (diff_x == '0);
    ctrl_a.y_zero = (diff_y == '0);
    ctrl_a.x_neg  = diff_x[DIFF_BITS-1];
    ctrl_a.y_neg  = diff_y[DIFF_BITS-1];
  end

  // Leading-one search on the larger magnitude gives the normalising shift.
  always_comb begin
    big = (a_mag_x > a_mag_y) ? a_mag_x : a_mag_y;
    msb = '0;
    for (int i = 0; i < DIFF_BITS; i++) begin
      if (big[i]) begin
        msb = fswp_pkg::SHIFT_BITS'(i);
      end
    end
    shift_next = fswp_pkg::SHIFT_BITS'(fswp_pkg::NORM_TOP) - msb;
  end

  // Zero-extend the magnitudes into the datapath width before shifting.
  always_comb begin
    ext_x = fswp_pkg::WORK_BITS'(b_mag_x);
    ext_y = fswp_pkg::WORK_BITS'(b_mag_y);
  end

  // Valid bits follow their beats through the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= valid_in;
      end
      if (en[1]) begin
        valid[1] <= valid[0];
      end
      if (en[2]) begin
        valid[2] <= valid[1];
      end
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_mag_x <= mag_x;
      a_mag_y <= mag_y;
      a_ctrl  <= ctrl_a;
    end
    if (en[1]) begin
      b_mag_x <= a_mag_x;
      b_mag_y <= a_mag_y;
      b_shift <= shift_next;
      b_ctrl  <= a_ctrl;
    end
    if (en[2]) begin
      x0   <= ext_x << b_shift;
      y0   <= ext_y << b_shift;
      ctrl <= b_ctrl;
    end
  end

endmodule

`default_nettype wire

// File: sv/fswp_cordic_stage.sv
// One vectoring-mode CORDIC iteration with its pipeline register.
`default_nettype none

module fswp_cordic_stage #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             valid_in,
  input  wire fswp_pkg::work_t  x_in,
  input  wire fswp_pkg::work_t  y_in,
  input  wire fswp_pkg::angle_t z_in,
  input  wire fswp_pkg::ctrl_t  ctrl_in,
  output logic                  valid,
  output fswp_pkg::work_t       x,
  output fswp_pkg::work_t       y,
  output fswp_pkg::angle_t      z,
  output fswp_pkg::ctrl_t       ctrl
);

  localparam fswp_pkg::angle_t ARC = fswp_pkg::angle_t'({1'b0, fswp_pkg::arc_angle(STEP)});

  fswp_pkg::work_t  x_shr;
  fswp_pkg::work_t  y_shr;
  fswp_pkg::work_t  x_next;
  fswp_pkg::work_t  y_next;
  fswp_pkg::angle_t z_next;

  // Rotate towards the x axis; the sign of y picks the direction.
  always_comb begin
    x_shr = x_in >>> STEP;
    y_shr = y_in >>> STEP;
    if (!y_in[fswp_pkg::WORK_BITS-1]) begin
      x_next = x_in + y_shr;
      y_next = y_in - x_shr;
      z_next = z_in + ARC;
    end else begin
      x_next = x_in - y_shr;
      y_next = y_in + x_shr;
      z_next = z_in - ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      ctrl <= ctrl_in;
    end
  end

endmodule

`default_nettype wire

// File: sv/fswp_back.sv
// Final stage: angle clamp, quadrant placement, rounding and the output register.
`default_nettype none

module fswp_back #(
  parameter int PHASE_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             valid_in,
  input  wire fswp_pkg::angle_t z_in,
  input  wire fswp_pkg::ctrl_t  ctrl_in,
  output logic                  valid,
  output logic [PHASE_BITS:0]   wrapped_phase
);

  localparam int DROP = 32 - PHASE_BITS;

  localparam logic [PHASE_BITS:0] FULL    = {1'b1, {PHASE_BITS{1'b0}}};
  localparam logic [PHASE_BITS:0] HALF    = FULL >> 1;
  localparam logic [PHASE_BITS:0] QUARTER = FULL >> 2;
  localparam logic [PHASE_BITS:0] THREE_Q = HALF + QUARTER;

  localparam logic [fswp_pkg::ANGLE_BITS:0] ROUND_HALF =
      (fswp_pkg::ANGLE_BITS + 1)'(1) << (DROP - 1);

  logic [fswp_pkg::QUAD_BITS-1:0]  quad;
  logic [fswp_pkg::ANGLE_BITS-1:0] placed;
  logic [fswp_pkg::ANGLE_BITS:0]   rounded;
  logic                            x_pos;
  logic                            y_pos;
  logic [PHASE_BITS:0]             phase_next;

  // Clamp the accumulated angle to a quarter turn.
  always_comb begin
    if (z_in[fswp_pkg::ANGLE_BITS-1]) begin
      quad = '0;
    end else if (z_in > fswp_pkg::angle_t'(fswp_pkg::QUAD_MAX)) begin
      quad = fswp_pkg::QUAD_MAX;
    end else begin
      quad = z_in[fswp_pkg::QUAD_BITS-1:0];
    end
  end

  // Place the angle in its quadrant, round half up, and handle the axes.
  always_comb begin
    x_pos = !ctrl_in.x_neg && !ctrl_in.x_zero;
    y_pos = !ctrl_in.y_neg && !ctrl_in.y_zero;
    if (y_pos) begin
      placed = x_pos ? fswp_pkg::ANGLE_BITS'(quad)
                     : fswp_pkg::ANGLE_HALF - fswp_pkg::ANGLE_BITS'(quad);
    end else begin
      placed = ctrl_in.x_neg ? fswp_pkg::ANGLE_HALF + fswp_pkg::ANGLE_BITS'(quad)
                             : fswp_pkg::ANGLE_FULL - fswp_pkg::ANGLE_BITS'(quad);
    end
    rounded = {1'b0, placed} + ROUND_HALF;
    if (ctrl_in.y_zero) begin
      phase_next = x_pos ? FULL : HALF;
    end else if (ctrl_in.x_zero) begin
      phase_next = y_pos ? QUARTER : THREE_Q;
    end else begin
      phase_next = rounded[32:DROP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrapped_phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/four_step_wrapped_phase.sv
// Four-step phase-shifting wrapped phase: a pipelined CORDIC arctangent per pixel.
//
// The pixel channel takes one beat per pixel carrying the four phase-shifted
// samples; the phase channel returns one beat per pixel with the wrapped
// phase atan2(d - b, a - c) on 0..2pi, in units of 2pi / 2^PHASE_BITS
// (2^PHASE_BITS itself means exactly 2pi). Results leave in input order.
// The datapath is 34 register stages: three front stages (differences,
// leading-one search, normalising shift), one stage per CORDIC iteration
// (30 of them) and one stage for quadrant placement and rounding. One
// pixel is accepted per clock while the phase channel is ready or a stage
// is empty; the CORDIC iteration stages make up most of the depth.
// Each stage holds its beat while the stage after it cannot load, so a stall on
// the phase channel fills the empty stages first and only then lowers ready
// on the pixel channel; no beat is dropped or repeated.
// The synchronous reset clears every valid bit; the block keeps no other
// state and needs no set-up before the first pixel.
`default_nettype none

module four_step_wrapped_phase #(
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_BITS  = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  fswp_in_if.sink   pixel,
  fswp_out_if.source phase
);

  localparam int STAGES = fswp_pkg::STAGES;
  localparam int FRONT  = fswp_pkg::FRONT_STAGES;
  localparam int STEPS  = fswp_pkg::CORDIC_STEPS;

  localparam fswp_pkg::work_t RESIDUE = fswp_pkg::work_t'(65536);

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  fswp_pkg::work_t  cx [STEPS+1];
  fswp_pkg::work_t  cy [STEPS+1];
  fswp_pkg::angle_t cz [STEPS+1];
  fswp_pkg::ctrl_t  cc [STEPS+1];

  fswp_pkg::work_t  norm_big;

  // A stage may load when it is empty or the stage after it is loading.
  assign en[STAGES-1] = !v[STAGES-1] || phase.ready;
  for (genvar k = 0; k < STAGES - 1; k++) begin : g_enable
    assign en[k] = !v[k] || en[k+1];
  end

  assign pixel.ready = en[0];
  assign phase.valid = v[STAGES-1];
  assign cz[0]       = '0;

  // Differences, shift search and normalisation.
  fswp_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en[FRONT-1:0]),
    .valid_in (pixel.valid),
    .sample_a (pixel.sample_a),
    .sample_b (pixel.sample_b),
    .sample_c (pixel.sample_c),
    .sample_d (pixel.sample_d),
    .valid    (v[FRONT-1:0]),
    .x0       (cx[0]),
    .y0       (cy[0]),
    .ctrl     (cc[0])
  );

  // One CORDIC iteration per stage.
  for (genvar k = 0; k < STEPS; k++) begin : g_cordic
    fswp_cordic_stage #(
      .STEP (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en[FRONT+k]),
      .valid_in (v[FRONT+k-1]),
      .x_in     (cx[k]),
      .y_in     (cy[k]),
      .z_in     (cz[k]),
      .ctrl_in  (cc[k]),
      .valid    (v[FRONT+k]),
      .x        (cx[k+1]),
      .y        (cy[k+1]),
      .z        (cz[k+1]),
      .ctrl     (cc[k+1])
    );
  end

  // Quadrant placement, rounding and the output register.
  fswp_back #(
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .en            (en[STAGES-1]),
    .valid_in      (v[STAGES-2]),
    .z_in          (cz[STEPS]),
    .ctrl_in       (cc[STEPS]),
    .valid         (v[STAGES-1]),
    .wrapped_phase (phase.wrapped_phase)
  );

  // Larger of the two normalised magnitudes entering the CORDIC.
  assign norm_big = (cx[0] > cy[0]) ? cx[0] : cy[0];

  // Reset empties the pipeline, so no beat is offered just after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !phase.valid)
    else $error("phase beat offered right after reset");

  // The pixel channel only back-pressures when every stage holds a beat.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> (&v))
    else $error("pixel channel stalled while the pipeline has a free stage");

  // The larger magnitude enters the CORDIC with its leading one at bit NORM_TOP.
  a_normalised: assert property (@(posedge clk) disable iff (rst)
    v[FRONT-1] && !cc[0].x_zero && !cc[0].y_zero |->
      norm_big[fswp_pkg::NORM_TOP] &&
      (norm_big[fswp_pkg::WORK_BITS-1:fswp_pkg::NORM_TOP+1] == '0))
    else $error("CORDIC input not normalised");

  // After the last iteration the x component of the vector is still positive.
  a_x_positive: assert property (@(posedge clk) disable iff (rst)
    v[STAGES-2] && !cc[STEPS].x_zero && !cc[STEPS].y_zero |-> cx[STEPS] > 0)
    else $error("CORDIC x went non-positive");

  // The residual y after the last iteration is small against the normalised x.
  a_y_residue: assert property (@(posedge clk) disable iff (rst)
    v[STAGES-2] && !cc[STEPS].x_zero && !cc[STEPS].y_zero |->
      (cy[STEPS] < RESIDUE) && (cy[STEPS] > -RESIDUE))
    else $error("CORDIC did not converge towards the x axis");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the four-step wrapped-phase pipeline.
`timescale 1ns / 100ps

module testbench;

  localparam int SAMPLE_BITS = 16;
  localparam int PHASE_BITS  = 16;
  localparam int RANDOM_PIXELS = 1550;
  localparam int ARC_STEPS = 30;

  // Phase codes on the 2^PHASE_BITS turn.
  localparam logic [PHASE_BITS:0] PHASE_FULL    = 17'd65536;
  localparam logic [PHASE_BITS:0] PHASE_HALF    = 17'd32768;
  localparam logic [PHASE_BITS:0] PHASE_QUARTER = 17'd16384;
  localparam logic [PHASE_BITS:0] PHASE_THREE_Q = 17'd49152;

  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7fff;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic signed [SAMPLE_BITS-1:0] sample_c;
    logic signed [SAMPLE_BITS-1:0] sample_d;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idling_on = 1'b1;
  int   stall_left = 0;

  fswp_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) pixel_if ();
  fswp_out_if #(.PHASE_BITS(PHASE_BITS))   phase_if ();

  four_step_wrapped_phase #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .pixel(pixel_if),
    .phase(phase_if)
  );

  // Holds the phases still owed by the pipeline and works out each new one.
  class phase_board;
    logic [PHASE_BITS:0] awaited[$];
    int unsigned pixels_noted = 0;
    int unsigned axis_pixels = 0;
    int unsigned failures = 0;

    // Axis cases first; else a vectoring CORDIC on the normalised magnitudes, then quadrant placement and rounding.
    function logic [PHASE_BITS:0] phase_of(pixel_t px);
      longint arc[ARC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1};
      longint dx, dy, mag_x, mag_y, top, vx, vy, nx, ny, acc, turn, rounded;
      int sh;
      dx = longint'(px.sample_a) - longint'(px.sample_c);
      dy = longint'(px.sample_d) - longint'(px.sample_b);
      if (dy == 0) begin
        return (dx > 0) ? PHASE_FULL : PHASE_HALF;
      end
      if (dx == 0) begin
        return (dy > 0) ? PHASE_QUARTER : PHASE_THREE_Q;
      end
      mag_x = (dx < 0) ? -dx : dx;
      mag_y = (dy < 0) ? -dy : dy;
      top = (mag_x > mag_y) ? mag_x : mag_y;
      sh = 0;
      while (sh < 63 && (top << sh) < (64'sd1 << 40)) begin
        sh++;
      end
      vx = mag_x << sh;
      vy = mag_y << sh;
      acc = 0;
      for (int i = 0; i < ARC_STEPS; i++) begin
        if (vy >= 0) begin
          nx = vx + (vy >>> i);
          ny = vy - (vx >>> i);
          acc += arc[i];
        end else begin
          nx = vx - (vy >>> i);
          ny = vy + (vx >>> i);
          acc -= arc[i];
        end
        vx = nx;
        vy = ny;
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
      // Place the first-quadrant angle on the full turn.
      if (dy > 0) begin
        turn = (dx > 0) ? acc : (64'sd1 << 31) - acc;
      end else begin
        turn = (dx < 0) ? (64'sd1 << 31) + acc : (64'sd1 << 32) - acc;
      end
      rounded = (turn + (64'sd1 << (31 - PHASE_BITS))) >>> (32 - PHASE_BITS);
      if (rounded > longint'(PHASE_FULL)) rounded = longint'(PHASE_FULL);
      return rounded[PHASE_BITS:0];
    endfunction

    function void note_pixel(pixel_t px);
      awaited = {awaited, phase_of(px)};
      pixels_noted++;
      if (px.sample_a == px.sample_c || px.sample_b == px.sample_d) axis_pixels++;
    endfunction

    function void check_phase(logic [PHASE_BITS:0] got);
      logic [PHASE_BITS:0] want;
      if (awaited.size() == 0) begin
        $error("wrapped_phase: expected nothing, got %0d", got);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        $error("wrapped_phase: expected %0d, got %0d", want, got);
        failures++;
      end
    endfunction
  endclass

  phase_board board = new;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Phase channel: check every beat taken and, while idling is on, stall ready in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      phase_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (phase_if.valid && phase_if.ready) board.check_phase(phase_if.wrapped_phase);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        phase_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 4);
        phase_if.ready <= 1'b0;
      end else begin
        phase_if.ready <= 1'b1;
      end
    end
  end

  // Present one pixel and hold it until the pipeline takes the beat.
  task automatic send_pixel(input pixel_t px);
    pixel_if.valid    <= 1'b1;
    pixel_if.sample_a <= px.sample_a;
    pixel_if.sample_b <= px.sample_b;
    pixel_if.sample_c <= px.sample_c;
    pixel_if.sample_d <= px.sample_d;
    @(posedge clk);
    while (!pixel_if.ready) @(posedge clk);
    board.note_pixel(px);
  endtask

  task automatic send_samples(input int a, input int b, input int c, input int d);
    pixel_t px;
    px.sample_a = a[SAMPLE_BITS-1:0];
    px.sample_b = b[SAMPLE_BITS-1:0];
    px.sample_c = c[SAMPLE_BITS-1:0];
    px.sample_d = d[SAMPLE_BITS-1:0];
    send_pixel(px);
  endtask

  task automatic idle_pixels(input int cycles);
    pixel_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off the pixel channel until every owed phase has come back.
  task automatic wait_drained();
    pixel_if.valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic int any_sample();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random pixels, weighted towards the awkward corners of the arctangent.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int kind, base, m, k;
    int edges[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    kind = $urandom_range(0, 9);
    case (kind)
      4: begin
        // Small differences around a common level.
        base = any_sample();
        px.sample_a = SAMPLE_BITS'(base + int'($urandom_range(0, 16)) - 8);
        px.sample_b = SAMPLE_BITS'(base + int'($urandom_range(0, 16)) - 8);
        px.sample_c = SAMPLE_BITS'(base + int'($urandom_range(0, 16)) - 8);
        px.sample_d = SAMPLE_BITS'(base + int'($urandom_range(0, 16)) - 8);
      end
      5: begin
        // Equal first and third samples: the vertical axis.
        px.sample_a = SAMPLE_BITS'(any_sample());
        px.sample_b = SAMPLE_BITS'(any_sample());
        px.sample_d = SAMPLE_BITS'(any_sample());
        px.sample_c = px.sample_a;
      end
      6: begin
        // Equal second and fourth samples: the horizontal axis.
        px.sample_a = SAMPLE_BITS'(any_sample());
        px.sample_b = SAMPLE_BITS'(any_sample());
        px.sample_c = SAMPLE_BITS'(any_sample());
        px.sample_d = px.sample_b;
      end
      7: begin
        // Equal magnitudes: the diagonals of every quadrant.
        m = $urandom_range(1, 32767);
        base = int'($urandom_range(0, 65535 - m)) - 32768;
        if ($urandom_range(0, 1)) begin
          px.sample_a = SAMPLE_BITS'(base + m);
          px.sample_c = SAMPLE_BITS'(base);
        end else begin
          px.sample_a = SAMPLE_BITS'(base);
          px.sample_c = SAMPLE_BITS'(base + m);
        end
        base = int'($urandom_range(0, 65535 - m)) - 32768;
        if ($urandom_range(0, 1)) begin
          px.sample_d = SAMPLE_BITS'(base + m);
          px.sample_b = SAMPLE_BITS'(base);
        end else begin
          px.sample_d = SAMPLE_BITS'(base);
          px.sample_b = SAMPLE_BITS'(base + m);
        end
      end
      8: begin
        // Large positive x and a tiny negative y: the turn rounds up towards 2pi.
        px.sample_a = SAMPLE_BITS'($urandom_range(16384, 32767));
        px.sample_c = SAMPLE_BITS'(-int'($urandom_range(16384, 32768)));
        k = $urandom_range(1, 3);
        base = int'($urandom_range(0, 65535 - k)) - 32768 + k;
        px.sample_b = SAMPLE_BITS'(base);
        px.sample_d = SAMPLE_BITS'(base - k);
      end
      9: begin
        px.sample_a = SAMPLE_BITS'(edges[$urandom_range(0, 6)]);
        px.sample_b = SAMPLE_BITS'(edges[$urandom_range(0, 6)]);
        px.sample_c = SAMPLE_BITS'(edges[$urandom_range(0, 6)]);
        px.sample_d = SAMPLE_BITS'(edges[$urandom_range(0, 6)]);
      end
      default: begin
        px = {$urandom(), $urandom()};
      end
    endcase
    return px;
  endfunction

  // Idling is switched off for one stretch mid-run and for the final stretch.
  function automatic bit idle_phase(int k);
    return !((k >= 600 && k < 800) || k >= 1250);
  endfunction

  // Stimulus: reset, directed corners, then the random stream.
  initial begin
    pixel_if.valid = 1'b0;
    pixel_if.sample_a = '0;
    pixel_if.sample_b = '0;
    pixel_if.sample_c = '0;
    pixel_if.sample_d = '0;
    phase_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // All four equal, and both axes in both directions.
    send_samples(0, 0, 0, 0);
    send_samples(-32768, -32768, -32768, -32768);
    send_samples(100, 7, 50, 7);
    send_samples(-50, 7, 100, 7);
    send_samples(9, -20, 9, 300);
    send_samples(9, 300, 9, -20);
    // Widest differences on both axes.
    send_samples(32767, -32768, -32768, 32767);
    send_samples(-32768, 32767, 32767, -32768);
    send_samples(32767, 32767, -32768, -32768);
    send_samples(-32768, -32768, 32767, 32767);
    // One quadrant each, and the diagonals.
    send_samples(300, 0, 100, 150);
    send_samples(-300, 0, 100, 150);
    send_samples(-300, 150, 100, 0);
    send_samples(300, 150, 100, 0);
    send_samples(1000, 0, 0, 1000);
    send_samples(0, 0, 1000, 1000);
    send_samples(0, 1000, 1000, 0);
    send_samples(1000, 1000, 0, 0);
    // Unit differences next to the axes, one rounding up to a full turn, and unit diagonals.
    send_samples(32767, 1, -32768, 0);
    send_samples(1, -32768, 0, 32767);
    send_samples(-1, 0, 0, 1);
    send_samples(1, 0, 0, -1);
    wait_drained();

    for (int k = 0; k < RANDOM_PIXELS; k++) begin
      idling_on <= idle_phase(k);
      if (k == 1000) wait_drained();
      if (idle_phase(k) && $urandom_range(0, 3) == 0) idle_pixels($urandom_range(1, 5));
      send_pixel(random_pixel());
    end

    wait_drained();
    repeat (fswp_pkg::STAGES + 10) @(posedge clk);
    $display("Sent %0d pixels (%0d on an axis), directed corners then random ones,",
             board.pixels_noted, board.axis_pixels);
    $display("with random idling on both channels and stretches of none.");
    if (board.failures == 0) begin
      $display("four_step_wrapped_phase: match");
    end else begin
      $display("four_step_wrapped_phase: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #5_000_000;
    $display("four_step_wrapped_phase: mismatch");
    $finish;
  end

endmodule

// File: files.f
sv/fswp_pkg.sv
sv/fswp_in_if.sv
sv/fswp_out_if.sv
sv/fswp_front.sv
sv/fswp_cordic_stage.sv
sv/fswp_back.sv
sv/four_step_wrapped_phase.sv
sim/testbench.sv
